/* design/fae_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fae_pkg
// Shared constants, request codes and controller/datapath interface types
// for the frame allocator.
// ----------------------------------------------------------------------------
package fae_pkg;

    localparam int NUM_FRAMES_DEF     = 64;
    localparam int FALLBACK_FRAME_DEF = 50;

    // fixed field widths of the item ports
    localparam int REQ_W = 2;
    localparam int TID_W = 16;
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC         = 2'd0,
        REQ_RELEASE_ONE   = 2'd1,
        REQ_RELEASE_OWNER = 2'd2
    } t_req;

    // controller -> datapath
    typedef struct packed {
        logic accept;     // latch item, clear trackers and results
        logic start;      // begin a scan over all frames
        logic one;        // release a single frame
        logic grant;      // commit the chosen frame
        logic load_out;   // move results into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic req_alloc;
        logic scan_done;
    } t_status;

endpackage

`default_nettype wire

/* design/fae_controller.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fae_controller
// Sequencer for one item at a time, plus the output handshake.
// ----------------------------------------------------------------------------
module fae_controller (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic [fae_pkg::REQ_W-1:0] i_req_type,
    output logic                           o_stall,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output fae_pkg::t_cmd                  o_cmd,
    input  wire fae_pkg::t_status          i_sts
);
    import fae_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_DECIDE = 6'b000100,
        S_ONE    = 6'b001000,
        S_GRANT  = 6'b010000,
        S_FIN    = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   accept;
    logic   out_free;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.accept = 1'b1;
                    case (i_req_type)
                        REQ_ALLOC, REQ_RELEASE_OWNER: begin
                            o_cmd.start = 1'b1;
                            n_state     = S_SCAN;
                        end
                        REQ_RELEASE_ONE: n_state = S_ONE;
                        default:         n_state = S_FIN;
                    endcase
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                // victim/free frame owner is read here for the grant cycle
                n_state = i_sts.req_alloc ? S_GRANT : S_FIN;
            end
            S_ONE: begin
                o_cmd.one = 1'b1;
                n_state   = S_FIN;
            end
            S_GRANT: begin
                o_cmd.grant = 1'b1;
                n_state     = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

/* design/fae_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fae_datapath
// Frame flags, owner memory, scan counter, victim trackers and result
// registers.
// ----------------------------------------------------------------------------
module fae_datapath #(
    parameter int NUM_FRAMES     = fae_pkg::NUM_FRAMES_DEF,
    parameter int FALLBACK_FRAME = fae_pkg::FALLBACK_FRAME_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire fae_pkg::t_cmd             i_cmd,
    output fae_pkg::t_status               o_sts,
    input  wire logic [fae_pkg::REQ_W-1:0] i_req_type,
    input  wire logic [fae_pkg::TID_W-1:0] i_thread_id,
    input  wire logic                      i_page_is_stack,
    input  wire logic [fae_pkg::IDX_W-1:0] i_release_index,
    output logic      [fae_pkg::IDX_W-1:0] o_frame_index,
    output logic                           o_evicted,
    output logic      [fae_pkg::TID_W-1:0] o_previous_owner,
    output logic      [fae_pkg::CNT_W-1:0] o_frames_released
);
    import fae_pkg::*;

    localparam int IW = $clog2(NUM_FRAMES);
    localparam int CW = $clog2(NUM_FRAMES + 1);
    localparam int FB = (FALLBACK_FRAME >= NUM_FRAMES) ? NUM_FRAMES - 1 : FALLBACK_FRAME;
    localparam logic [IW-1:0] FB_IDX   = IW'(FB);
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_FRAMES - 1);

    // latched item
    logic [REQ_W-1:0] r_req;
    logic [TID_W-1:0] r_tid;
    logic             r_stack;
    logic [IDX_W-1:0] r_rel;

    // frame flags
    logic [NUM_FRAMES-1:0] r_in_use;
    logic [NUM_FRAMES-1:0] r_holds_stack;

    // owner memory, one read port, one write port
    logic [TID_W-1:0] r_mem [NUM_FRAMES];
    logic [TID_W-1:0] r_rd_data;
    logic [IW-1:0]    rd_addr;

    // scan
    logic          r_issue;
    logic          r_chk;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_idx_d;

    // candidates
    logic          r_found_free, r_found_first, r_found_high;
    logic [IW-1:0] r_free_idx, r_first_idx, r_high_idx;
    logic [CW-1:0] r_count;

    // results
    logic [IW-1:0]    r_res_frame;
    logic             r_res_ev;
    logic [TID_W-1:0] r_res_prev;

    logic [IDX_W-1:0] r_out_frame;
    logic             r_out_ev;
    logic [TID_W-1:0] r_out_prev;
    logic [CNT_W-1:0] r_out_count;

    logic [IW-1:0] frame_sel;
    logic [IW-1:0] victim;
    logic [IW-1:0] rel_idx;
    logic          rel_hit;
    logic          is_alloc;
    logic          is_owner;
    logic          owner_hit;

    assign is_alloc = (r_req == REQ_ALLOC);
    assign is_owner = (r_req == REQ_RELEASE_OWNER);

    assign victim    = r_found_first ? r_first_idx :
                       r_found_high  ? r_high_idx  : FB_IDX;
    assign frame_sel = r_found_free ? r_free_idx : victim;

    assign rel_idx = IW'(r_rel);
    assign rel_hit = (int'(r_rel) < NUM_FRAMES) && r_in_use[rel_idx];

    assign owner_hit = r_chk && is_owner && r_in_use[r_idx_d] && (r_rd_data == r_tid);

    assign rd_addr = r_issue ? r_idx : frame_sel;

    assign o_sts.req_alloc = is_alloc;
    assign o_sts.scan_done = r_chk && (r_idx_d == LAST_IDX);

    // scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_chk   <= 1'b0;
        end else begin
            r_chk <= r_issue;
            if (i_cmd.start) begin
                r_issue <= 1'b1;
            end else if (r_issue && (r_idx == LAST_IDX)) begin
                r_issue <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_idx <= '0;
        end else if (r_issue) begin
            r_idx <= IW'(r_idx + 1'b1);
        end
        r_idx_d <= r_idx;
    end

    // item latch, candidate tracking, results
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req         <= i_req_type;
            r_tid         <= i_thread_id;
            r_stack       <= i_page_is_stack;
            r_rel         <= i_release_index;
            r_found_free  <= 1'b0;
            r_found_first <= 1'b0;
            r_found_high  <= 1'b0;
            r_count       <= '0;
            r_res_frame   <= '0;
            r_res_ev      <= 1'b0;
            r_res_prev    <= '0;
        end else begin
            if (r_chk && is_alloc) begin
                if (!r_in_use[r_idx_d] && !r_found_free) begin
                    r_found_free <= 1'b1;
                    r_free_idx   <= r_idx_d;
                end
                // owner data only matters when every frame is in use
                if ((r_rd_data != r_tid) && !r_holds_stack[r_idx_d] && !r_found_first) begin
                    r_found_first <= 1'b1;
                    r_first_idx   <= r_idx_d;
                end
                // ascending scan: the last hit is the highest, frame 0 excluded
                if ((r_idx_d != '0) && !r_holds_stack[r_idx_d]) begin
                    r_found_high <= 1'b1;
                    r_high_idx   <= r_idx_d;
                end
            end
            if (owner_hit) begin
                r_count <= CW'(r_count + 1'b1);
            end
            if (i_cmd.one && rel_hit) begin
                r_count <= CW'(1);
            end
            if (i_cmd.grant) begin
                r_res_frame <= frame_sel;
                r_res_ev    <= !r_found_free;
                r_res_prev  <= r_found_free ? '0 : r_rd_data;
            end
        end
    end

    // frame flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use      <= '0;
            r_holds_stack <= '0;
        end else begin
            if (owner_hit) begin
                r_in_use[r_idx_d]      <= 1'b0;
                r_holds_stack[r_idx_d] <= 1'b0;
            end
            if (i_cmd.one && rel_hit) begin
                r_in_use[rel_idx]      <= 1'b0;
                r_holds_stack[rel_idx] <= 1'b0;
            end
            if (i_cmd.grant) begin
                r_in_use[frame_sel]      <= 1'b1;
                r_holds_stack[frame_sel] <= r_stack;
            end
        end
    end

    // owner memory; entries of free frames may be read but never count
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
        if (i_cmd.grant) begin
            r_mem[frame_sel] <= r_tid;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_frame <= IDX_W'(r_res_frame);
            r_out_ev    <= r_res_ev;
            r_out_prev  <= r_res_prev;
            r_out_count <= CNT_W'(r_count);
        end
    end

    assign o_frame_index     = r_out_frame;
    assign o_evicted         = r_out_ev;
    assign o_previous_owner  = r_out_prev;
    assign o_frames_released = r_out_count;

endmodule

`default_nettype wire

/* design/frame_allocator_with_eviction.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// frame_allocator_with_eviction
// Physical frame table: allocate with eviction, release one, release by owner.
// ----------------------------------------------------------------------------
// One item is processed at a time. Allocate and release-by-owner walk the
// whole frame table, one frame per cycle through the single read port of the
// owner memory, then a decide state; allocate then commits the frame in a
// grant state. Release-one skips the walk; an unknown request goes straight
// to the result. Results sit in an output register, so the next item is
// taken while a result still waits downstream. No clearing pass after reset:
// the in-use and stack flags are flip-flops cleared by reset, and the owner
// memory contents only count for frames that are in use.
// ----------------------------------------------------------------------------
module frame_allocator_with_eviction #(
    parameter int NUM_FRAMES     = fae_pkg::NUM_FRAMES_DEF,
    parameter int FALLBACK_FRAME = fae_pkg::FALLBACK_FRAME_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [fae_pkg::REQ_W-1:0] i_req_type,
    input  wire logic [fae_pkg::TID_W-1:0] i_thread_id,
    input  wire logic                      i_page_is_stack,
    input  wire logic [fae_pkg::IDX_W-1:0] i_release_index,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic      [fae_pkg::IDX_W-1:0] o_frame_index,
    output logic                           o_evicted,
    output logic      [fae_pkg::TID_W-1:0] o_previous_owner,
    output logic      [fae_pkg::CNT_W-1:0] o_frames_released
);
    import fae_pkg::*;

    t_cmd    cmd;
    t_status sts;

    fae_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_req_type (i_req_type),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    fae_datapath #(
        .NUM_FRAMES     (NUM_FRAMES),
        .FALLBACK_FRAME (FALLBACK_FRAME)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_req_type        (i_req_type),
        .i_thread_id       (i_thread_id),
        .i_page_is_stack   (i_page_is_stack),
        .i_release_index   (i_release_index),
        .o_frame_index     (o_frame_index),
        .o_evicted         (o_evicted),
        .o_previous_owner  (o_previous_owner),
        .o_frames_released (o_frames_released)
    );

endmodule

`default_nettype wire

/* design/fae_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fae_checker
// Port-level checks on the frame allocator's output channel.
// ----------------------------------------------------------------------------
module fae_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      o_valid,
    input wire logic                      i_stall,
    input wire logic [fae_pkg::IDX_W-1:0] o_frame_index,
    input wire logic                      o_evicted,
    input wire logic [fae_pkg::TID_W-1:0] o_previous_owner,
    input wire logic [fae_pkg::CNT_W-1:0] o_frames_released
);
    import fae_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_frame_index) && $stable(o_evicted)
            && $stable(o_previous_owner) && $stable(o_frames_released))
        else $error("stalled result changed");

    // only an eviction reports a previous owner
    a_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_evicted |-> o_previous_owner == '0)
        else $error("previous owner without eviction");

    // a release never grants a frame
    a_rel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_frames_released != '0) |-> (o_frame_index == '0) && !o_evicted)
        else $error("release result carries a grant");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind frame_allocator_with_eviction fae_checker u_fae_checker (.*);

`default_nettype wire

/* tb/frame_allocator_with_eviction_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_allocator_with_eviction_test
// Self-checking bench for the frame table: allocate, evict, release.
// ----------------------------------------------------------------------------
// A queue of requests is built up front: a short directed list, then
// episodes that fill the table with a few owners and keep allocating so
// every eviction choice is reached, with some noise mixed in. A clocked
// driver feeds the queue through valid/stall and runs a frame-table model
// on every accepted item. A clocked monitor checks each result against the
// oldest predicted one. Both sides idle at random, and once the output side
// holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module frame_allocator_with_eviction_test;
    import fae_pkg::*;

    localparam int NFR           = NUM_FRAMES_DEF;
    localparam int FALLBACK_PICK = (FALLBACK_FRAME_DEF >= NUM_FRAMES_DEF) ?
                                   NUM_FRAMES_DEF - 1 : FALLBACK_FRAME_DEF;
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
    localparam int ITEM_TARGET   = 650;
    localparam int HOLD_CYCLES   = 800;
    localparam int HOLD_AT_ITEM  = 120;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int DRAIN_CYCLES  = 100;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [TID_W-1:0] thread_id;
        logic             page_is_stack;
        logic [IDX_W-1:0] release_index;
    } t_frame_req;

    typedef struct packed {
        logic [IDX_W-1:0] frame_index;
        logic             evicted;
        logic [TID_W-1:0] previous_owner;
        logic [CNT_W-1:0] frames_released;
    } t_frame_result;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic [REQ_W-1:0] i_req_type = '0;
    logic [TID_W-1:0] i_thread_id = '0;
    logic             i_page_is_stack = 1'b0;
    logic [IDX_W-1:0] i_release_index = '0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic [IDX_W-1:0] o_frame_index;
    logic             o_evicted;
    logic [TID_W-1:0] o_previous_owner;
    logic [CNT_W-1:0] o_frames_released;

    frame_allocator_with_eviction i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_req_type        (i_req_type),
        .i_thread_id       (i_thread_id),
        .i_page_is_stack   (i_page_is_stack),
        .i_release_index   (i_release_index),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_frame_index     (o_frame_index),
        .o_evicted         (o_evicted),
        .o_previous_owner  (o_previous_owner),
        .o_frames_released (o_frames_released)
    );

    // frame table model
    bit               frame_busy  [NFR];
    logic [TID_W-1:0] frame_owner [NFR] = '{default: '0};
    bit               frame_stack [NFR];

    t_frame_req    pending_reqs[$];
    t_frame_result expected_results[$];

    int n_accepted  = 0;
    int n_errors    = 0;
    int n_queued    = 0;
    int cycle_count = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    t_frame_req    next_req;
    t_frame_result want, got;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    task automatic report_mismatch(string what);
        $display("ERROR @%0t: %s", $time, what);
        n_errors++;
    endtask

    function automatic t_frame_result apply_request(t_frame_req r);
        t_frame_result res;
        int  f;
        int  grant;
        bit  found;
        res = '0;
        grant = 0;
        found = 1'b0;
        case (r.req_type)
            REQ_ALLOC: begin
                for (f = 0; f < NFR && !found; f++)
                    if (!frame_busy[f]) begin
                        grant = f;
                        found = 1'b1;
                    end
                if (!found) begin
                    // table full: foreign non-stack, then highest non-stack, then fallback
                    for (f = 0; f < NFR && !found; f++)
                        if (frame_owner[f] != r.thread_id && !frame_stack[f]) begin
                            grant = f;
                            found = 1'b1;
                        end
                    for (f = NFR - 1; f > 0 && !found; f--)
                        if (!frame_stack[f]) begin
                            grant = f;
                            found = 1'b1;
                        end
                    if (!found)
                        grant = FALLBACK_PICK;
                    res.evicted = 1'b1;
                    res.previous_owner = frame_owner[grant];
                end
                res.frame_index = grant[IDX_W-1:0];
                frame_busy[grant]  = 1'b1;
                frame_owner[grant] = r.thread_id;
                frame_stack[grant] = r.page_is_stack;
            end
            REQ_RELEASE_ONE: begin
                if (int'(r.release_index) < NFR && frame_busy[r.release_index]) begin
                    frame_busy[r.release_index]  = 1'b0;
                    frame_owner[r.release_index] = '0;
                    frame_stack[r.release_index] = 1'b0;
                    res.frames_released = CNT_W'(1);
                end
            end
            REQ_RELEASE_OWNER: begin
                for (f = 0; f < NFR; f++)
                    if (frame_busy[f] && frame_owner[f] == r.thread_id) begin
                        frame_busy[f]  = 1'b0;
                        frame_owner[f] = '0;
                        frame_stack[f] = 1'b0;
                        res.frames_released++;
                    end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic push_req(logic [REQ_W-1:0] kind, logic [TID_W-1:0] tid, bit stk,
                            logic [IDX_W-1:0] idx);
        t_frame_req r;
        r.req_type      = kind;
        r.thread_id     = tid;
        r.page_is_stack = stk;
        r.release_index = idx;
        pending_reqs.push_back(r);
        n_queued++;
    endtask

    function automatic logic [TID_W-1:0] pick_tid();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return TID_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // single_owner: one thread only, stack_pct picks how soon the non-stack
    // frames run out (second choice, then fallback once all are stack)
    task automatic add_episode(bit single_owner, int stack_pct, int nalloc, bit clear_all);
        logic [TID_W-1:0] pool [3];
        int npool, n, k;
        logic [REQ_W-1:0] kind;
        npool = single_owner ? 1 : $urandom_range(2, 3);
        for (k = 0; k < npool; k++)
            pool[k] = pick_tid();
        for (n = 0; n < nalloc && n_queued < ITEM_TARGET; n++) begin
            k = $urandom_range(0, npool - 1);
            if ($urandom_range(0, 99) < 8) begin
                if (single_owner)
                    kind = $urandom_range(0, 1) ? REQ_RELEASE_ONE : REQ_UNKNOWN;
                else
                    kind = REQ_W'($urandom_range(0, 3));
                push_req(kind, $urandom_range(0, 1) ? pool[k] : pick_tid(),
                         1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, NFR - 1)));
            end else begin
                push_req(REQ_ALLOC, pool[k], $urandom_range(0, 99) < stack_pct,
                         IDX_W'($urandom_range(0, NFR - 1)));
            end
        end
        if (clear_all) begin
            for (k = 0; k < npool; k++)
                push_req(REQ_RELEASE_OWNER, pool[k], 1'($urandom_range(0, 1)),
                         IDX_W'($urandom_range(0, NFR - 1)));
        end else begin
            for (k = 0; k < $urandom_range(1, 6); k++)
                push_req(REQ_RELEASE_ONE, pick_tid(), 1'($urandom_range(0, 1)),
                         IDX_W'($urandom_range(0, NFR - 1)));
        end
    endtask

    function automatic int idle_pct(bit sender);
        if (n_accepted < 230)
            return sender ? 11 : 67;
        else if (n_accepted < 460)
            return sender ? 67 : 11;
        return 0;
    endfunction

    // driver: prediction happens on acceptance, so it follows the block's order
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                next_req.req_type      = i_req_type;
                next_req.thread_id     = i_thread_id;
                next_req.page_is_stack = i_page_is_stack;
                next_req.release_index = i_release_index;
                expected_results.push_back(apply_request(next_req));
                n_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
                    next_req = pending_reqs.pop_front();
                    i_valid         <= 1'b1;
                    i_req_type      <= next_req.req_type;
                    i_thread_id     <= next_req.thread_id;
                    i_page_is_stack <= next_req.page_is_stack;
                    i_release_index <= next_req.release_index;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // output side stall, with one long hold-off to back the block up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_accepted >= HOLD_AT_ITEM) begin
            i_stall   <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < idle_pct(1'b0));
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got.frame_index     = o_frame_index;
            got.evicted         = o_evicted;
            got.previous_owner  = o_previous_owner;
            got.frames_released = o_frames_released;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %p", got));
            end else begin
                want = expected_results.pop_front();
                if (got.frame_index !== want.frame_index)
                    report_mismatch($sformatf("frame_index %0d, want %0d",
                                              got.frame_index, want.frame_index));
                if (got.evicted !== want.evicted)
                    report_mismatch($sformatf("evicted %0b, want %0b",
                                              got.evicted, want.evicted));
                if (got.previous_owner !== want.previous_owner)
                    report_mismatch($sformatf("previous_owner %h, want %h",
                                              got.previous_owner, want.previous_owner));
                if (got.frames_released !== want.frames_released)
                    report_mismatch($sformatf("frames_released %0d, want %0d",
                                              got.frames_released, want.frames_released));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        // directed: empty table corners, unknown request, releases of free frames
        push_req(REQ_UNKNOWN,       16'hFFFF, 1'b1, 6'd63);
        push_req(REQ_RELEASE_ONE,   16'h0000, 1'b0, 6'd0);
        push_req(REQ_RELEASE_OWNER, 16'h0000, 1'b0, 6'd0);
        push_req(REQ_ALLOC,         16'h0000, 1'b0, 6'd0);
        push_req(REQ_ALLOC,         16'hFFFF, 1'b1, 6'd63);
        push_req(REQ_ALLOC,         16'h1234, 1'b0, 6'd21);
        push_req(REQ_RELEASE_ONE,   16'hFFFF, 1'b1, 6'd1);
        push_req(REQ_ALLOC,         16'hAAAA, 1'b1, 6'd42);
        push_req(REQ_RELEASE_ONE,   16'h5555, 1'b0, 6'd63);
        push_req(REQ_RELEASE_OWNER, 16'hFFFF, 1'b1, 6'd63);
        push_req(REQ_RELEASE_OWNER, 16'hAAAA, 1'b0, 6'd1);
        // free frames hold owner zero in the model; they must not count here
        push_req(REQ_RELEASE_OWNER, 16'h0000, 1'b1, 6'd0);
        push_req(REQ_RELEASE_ONE,   16'h1234, 1'b0, 6'd2);
        push_req(REQ_UNKNOWN,       16'h0000, 1'b0, 6'd0);

        // fixed-shape episodes first, so every eviction choice shows up
        add_episode(1'b1, 50,  $urandom_range(80, 110), 1'b1);
        add_episode(1'b1, 100, $urandom_range(80, 120), 1'b1);
        add_episode(1'b0, 30,  $urandom_range(70, 100), 1'b1);
        while (n_queued < ITEM_TARGET) begin
            case ($urandom_range(0, 3))
                0:       add_episode(1'b1, 50, $urandom_range(40, 100), 1'b1);
                1:       add_episode(1'b1, 100, $urandom_range(66, 100), 1'b1);
                default: add_episode(1'b0, $urandom_range(0, 3) * 30,
                                     $urandom_range(20, 100), 1'($urandom_range(0, 1)));
            endcase
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (pending_reqs.size() > 0 || i_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
